### rtl/idba_pkg.sv
// ----------------------------------------------------------------------------
// idba_pkg: shared types and constants of the id bitmap allocator
// Transaction payload structs, operation and status codes, controller state
// encoding and the command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package idba_pkg;

  // Default sizing
  localparam int MAX_IDS_DEF  = 256;
  localparam int HANDLE_W_DEF = 32;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int OBJ_W    = 32;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 9;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ID_LIMIT = 1'b0;    // word address of id_limit
  localparam logic [LIMIT_W-1:0] ID_LIMIT_RST = 9'd256;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OBJ_W-1:0]  obj_handle;
    logic [ID_W-1:0]   id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_out;
    logic [OBJ_W-1:0]    handle_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_PICK
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the request
    logic find;   // locate the first word with a free id
    logic pick;   // resolve, commit and issue the result
  } idba_cmd_t;

endpackage

### rtl/id_bitmap_allocator_with_lookup_unit.sv
// ----------------------------------------------------------------------------
// id_bitmap_allocator_with_lookup_unit: id allocator with handle lookup
// Every transaction (insert, lookup or remove) passes the FIND and PICK
// states and then puts its result strobe out. In FIND the first 32-id word
// with a free id is found while the handle RAM is read. In PICK the bit is
// picked, committed and the result registered. busy is high in both. start
// is taken again in the cycle in which the result is shown, so no new
// transaction is accepted before the last result is out. The result is marked
// by out_valid for exactly one cycle; there is no back-pressure. The used
// bitmap is cleared at reset, so no clearing pass is needed. id_limit is an
// APB register at address 0 and should only be written while busy is low.
// ----------------------------------------------------------------------------
module id_bitmap_allocator_with_lookup_unit #(
  parameter int MAX_IDS  = idba_pkg::MAX_IDS_DEF,
  parameter int HANDLE_W = idba_pkg::HANDLE_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel
  input  logic                             start,
  output logic                             busy,
  input  idba_pkg::in_item_t               in_req,
  // Result channel
  output logic                             out_valid,
  output idba_pkg::out_item_t              out_rsp,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [idba_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [idba_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [idba_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import idba_pkg::*;

  logic [LIMIT_W-1:0] id_limit_r;
  logic               cfg_wr;
  idba_cmd_t          cmd;

  // Register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ID_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= ID_LIMIT_RST;
    end else if (cfg_wr) begin
      id_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ID_LIMIT)
                  ? {{(CFG_DATA_W-LIMIT_W){1'b0}}, id_limit_r} : '0;

  // Sequencer
  idba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Storage and search
  idba_datapath #(
    .MAX_IDS  (MAX_IDS),
    .HANDLE_W (HANDLE_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .id_limit  (id_limit_r),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

### rtl/idba_ctrl.sv
// ----------------------------------------------------------------------------
// idba_ctrl: transaction sequencer
// Steps each accepted transaction through the search and commit phases and
// reports busy to the requester.
// ----------------------------------------------------------------------------
module idba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output idba_pkg::idba_cmd_t cmd
);
  import idba_pkg::*;

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/idba_datapath.sv
// ----------------------------------------------------------------------------
// idba_datapath: bitmap, handle table and response logic
// Holds the used bitmap in flops, the handle table in a RAM, runs the
// two-step lowest-free search and forms the result of each transaction.
// ----------------------------------------------------------------------------
module idba_datapath #(
  parameter int MAX_IDS  = idba_pkg::MAX_IDS_DEF,
  parameter int HANDLE_W = idba_pkg::HANDLE_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idba_pkg::idba_cmd_t           cmd,
  input  idba_pkg::in_item_t            in_req,
  input  logic [idba_pkg::LIMIT_W-1:0]  id_limit,
  output logic                          out_valid,
  output idba_pkg::out_item_t           out_rsp
);
  import idba_pkg::*;

  // Geometry: search words of up to 32 ids, padding bits read as used
  localparam int IDX_W  = $clog2(MAX_IDS);
  localparam int WB     = (MAX_IDS < 32) ? MAX_IDS : 32;
  localparam int WB_W   = $clog2(WB);
  localparam int NW     = (MAX_IDS + WB - 1) / WB;
  localparam int NW_W   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNT_W  = $clog2(MAX_IDS + 1);
  localparam int LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  in_item_t              req_r;
  logic [MAX_IDS-1:0]    used_r;
  logic [HANDLE_W-1:0]   mem [MAX_IDS];
  logic [HANDLE_W-1:0]   rd_data_r;
  logic [NW_W-1:0]       word_idx_r;
  logic                  any_free_r;
  logic                  out_valid_r;
  out_item_t             rsp_r;

  logic [WB-1:0]         word_vec [NW];
  logic [NW-1:0]         word_full;
  logic [NW_W-1:0]       word_idx_nxt;
  logic [WB-1:0]         sel_word;
  logic [WB_W-1:0]       bit_idx;
  logic [LW-1:0]         eff_lim;
  logic [LW-1:0]         lim_ext;
  logic [LW-1:0]         id_ext;
  logic [LW-1:0]         n_wide;
  logic [IDX_W-1:0]      n_idx;
  logic [IDX_W-1:0]      id_idx;
  logic [ID_W-1:0]       n_id;
  logic [HANDLE_W-1:0]   wr_handle;
  logic [OBJ_W-1:0]      rd_handle;
  logic                  ins_ok;
  logic                  hit;
  logic                  is_ins;
  logic                  is_rem;
  out_item_t             rsp_nxt;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
    end
  end

  // Effective limit and id in comparison width
  assign lim_ext = {{(LW-LIMIT_W){1'b0}}, id_limit};
  assign eff_lim = (lim_ext > LW'(MAX_IDS)) ? LW'(MAX_IDS) : lim_ext;
  assign id_ext  = {{(LW-ID_W){1'b0}}, req_r.id};
  assign is_ins  = (req_r.mode == MODE_INSERT);
  assign is_rem  = (req_r.mode == MODE_REMOVE);

  // Width adaptation between fixed fields and parameterized storage
  generate
    if (IDX_W >= ID_W) begin : g_idx_wide
      assign id_idx = {{(IDX_W-ID_W){1'b0}}, req_r.id};
      assign n_id   = n_idx[ID_W-1:0];
    end else begin : g_idx_narrow
      assign id_idx = req_r.id[IDX_W-1:0];
      assign n_id   = {{(ID_W-IDX_W){1'b0}}, n_idx};
    end
    if (HANDLE_W >= OBJ_W) begin : g_h_wide
      assign wr_handle = {{(HANDLE_W-OBJ_W){1'b0}}, req_r.obj_handle};
      assign rd_handle = rd_data_r[OBJ_W-1:0];
    end else begin : g_h_narrow
      assign wr_handle = req_r.obj_handle[HANDLE_W-1:0];
      assign rd_handle = {{(OBJ_W-HANDLE_W){1'b0}}, rd_data_r};
    end
  endgenerate

  // Word view of the bitmap
  for (genvar w = 0; w < NW; w++) begin : g_word
    for (genvar b = 0; b < WB; b++) begin : g_bit
      if (w * WB + b < MAX_IDS) begin : g_real
        assign word_vec[w][b] = used_r[w * WB + b];
      end else begin : g_pad
        assign word_vec[w][b] = 1'b1;
      end
    end
    assign word_full[w] = &word_vec[w];
  end

  // First step: lowest word holding a free id
  always_comb begin
    word_idx_nxt = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (!word_full[w]) begin
        word_idx_nxt = NW_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      word_idx_r <= word_idx_nxt;
      any_free_r <= ~(&word_full);
    end
  end

  // Second step: lowest free bit inside the chosen word
  assign sel_word = word_vec[word_idx_r];

  always_comb begin
    bit_idx = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!sel_word[b]) begin
        bit_idx = WB_W'(b);
      end
    end
  end

  assign n_wide = LW'(word_idx_r) * LW'(WB) + LW'(bit_idx);
  assign n_idx  = n_wide[IDX_W-1:0];
  assign ins_ok = any_free_r && (n_wide < eff_lim);
  assign hit    = (id_ext < eff_lim) && used_r[id_idx];

  // Handle table: registered read at the requested id
  always_ff @(posedge clk) begin
    if (cmd.pick && is_ins && ins_ok) begin
      mem[n_idx] <= wr_handle;
    end
    rd_data_r <= mem[id_idx];
  end

  // Used bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.pick) begin
      if (is_ins && ins_ok) begin
        used_r[n_idx] <= 1'b1;
      end else if (is_rem && hit) begin
        used_r[id_idx] <= 1'b0;
      end
    end
  end

  // Response formation
  always_comb begin
    rsp_nxt.status     = STAT_MISSING;
    rsp_nxt.id_out     = req_r.id;
    rsp_nxt.handle_out = '0;
    case (req_r.mode)
      MODE_INSERT: begin
        if (ins_ok) begin
          rsp_nxt.status = STAT_OK;
          rsp_nxt.id_out = n_id;
        end else begin
          rsp_nxt.status = STAT_FULL;
          rsp_nxt.id_out = '0;
        end
      end
      MODE_LOOKUP, MODE_REMOVE: begin
        if (hit) begin
          rsp_nxt.status     = STAT_OK;
          rsp_nxt.handle_out = rd_handle;
        end
      end
      default: begin
        rsp_nxt.status = STAT_MISSING;
      end
    endcase
  end

  // Result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Allocation never hands out an id that is already taken
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick && is_ins && ins_ok |-> !used_r[n_idx])
    else $error("allocated id already in use");

  // Successful allocation marks the id used
  a_alloc_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick && is_ins && ins_ok |=> used_r[$past(n_idx)])
    else $error("allocated id not marked");

  // Successful remove frees the id
  a_remove_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick && is_rem && hit |=> !used_r[$past(id_idx)])
    else $error("removed id still marked");

  // Exactly one result strobe per commit
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |=> out_valid_r)
    else $error("missing result strobe");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.pick |=> !out_valid_r)
    else $error("spurious result strobe");

endmodule
